### design/rfpc_pkg.sv
// Shared types, widths and codes of the random fern posterior classifier.
package rfpc_pkg;

   localparam int DEF_NUM_FERNS  = 10;
   localparam int DEF_FERN_BITS  = 13;
   localparam int DEF_COUNT_BITS = 16;

   localparam int MAX_FERNS   = 10;
   localparam int LEAF_BITS   = 13;
   localparam int LEAF_EXT    = 16;
   localparam int POST_BITS   = 16;
   localparam int VOTE_BITS   = 20;
   localparam int CMD_BITS    = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 20;
   localparam int FRAC_BITS   = 16;
   localparam int DIV_STEPS   = POST_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [FRAC_BITS-1:0] FRAC_RESET  = 16'd39322;
   localparam logic [VOTE_BITS-1:0] NEG_RESET   = 20'd327680;
   localparam logic [POST_BITS-1:0] POST_ONE    = '1;

   localparam logic [CMD_BITS-1:0] CMD_MEASURE  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_TRAIN    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_EVALUATE = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POS_FRACTION = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEG_LIMIT    = 2'd1;

   typedef struct packed {
      logic clear;
      logic rd;
      logic load;
      logic step;
      logic write;
      logic label;
   } lane_ctl_type;

endpackage

### design/rfpc_lane.sv
// One fern lane: leaf store, counter update and iterative posterior divider.
module rfpc_lane import rfpc_pkg::*; #(
   parameter int FERN_BITS  = DEF_FERN_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                 clock,
   input  lane_ctl_type         ctl,
   input  logic [FERN_BITS-1:0] clear_addr,
   input  logic [FERN_BITS-1:0] leaf,
   output logic [POST_BITS-1:0] posterior,
   output logic                 incremented
);

   localparam int LEAVES    = 1 << FERN_BITS;
   localparam int WORD_BITS = 2 * COUNT_BITS + POST_BITS;

   logic [WORD_BITS-1:0] mem [LEAVES];
   logic [WORD_BITS-1:0] rd_ff;
   logic [FERN_BITS-1:0] addr_ff;
   logic [COUNT_BITS-1:0] pos_ff, pos_in, neg_ff, neg_in;
   logic [COUNT_BITS:0]   den_ff, rem_ff, rem_in;
   logic [COUNT_BITS+1:0] rem_dbl;
   logic [POST_BITS-1:0]  quo_ff;
   logic                  inc_ff;
   logic [COUNT_BITS-1:0] old_pos, old_neg, sel;
   logic                  bump;
   logic [POST_BITS-1:0]  post_wr;
   logic                  wr_en;
   logic [FERN_BITS-1:0]  wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   assign old_pos = rd_ff[WORD_BITS-1 -: COUNT_BITS];
   assign old_neg = rd_ff[POST_BITS +: COUNT_BITS];
   assign sel     = ctl.label ? old_pos : old_neg;
   assign bump    = (sel != '1);
   assign pos_in  = old_pos + COUNT_BITS'(ctl.label && bump);
   assign neg_in  = old_neg + COUNT_BITS'(!ctl.label && bump);

   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_in  = (rem_dbl >= {1'b0, den_ff}) ? (COUNT_BITS+1)'(rem_dbl - {1'b0, den_ff})
                                                : rem_dbl[COUNT_BITS:0];

   always_comb begin
      if (pos_ff == '0) begin
         post_wr = '0;
      end else if (neg_ff == '0) begin
         post_wr = POST_ONE;
      end else begin
         post_wr = quo_ff;
      end
   end

   assign wr_en   = ctl.clear || ctl.write;
   assign wr_addr = ctl.clear ? clear_addr : addr_ff;
   assign wr_data = ctl.clear ? '0 : {pos_ff, neg_ff, post_wr};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_ff   <= mem[leaf];
         addr_ff <= leaf;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pos_ff <= pos_in;
         neg_ff <= neg_in;
         den_ff <= {1'b0, pos_in} + {1'b0, neg_in};
         rem_ff <= {1'b0, pos_in};
         quo_ff <= '0;
         inc_ff <= bump;
      end else if (ctl.step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[POST_BITS-2:0], (rem_dbl >= {1'b0, den_ff})};
      end
   end

   assign posterior   = rd_ff[POST_BITS-1:0];
   assign incremented = inc_ff;

endmodule

### design/rfpc_merge.sv
// Merging stage: sums the lane posteriors into the vote and ORs the update flags.
module rfpc_merge import rfpc_pkg::*; #(
   parameter int NUM_FERNS = DEF_NUM_FERNS
) (
   input  logic [POST_BITS-1:0] posterior [NUM_FERNS],
   input  logic [NUM_FERNS-1:0] incremented,
   output logic [VOTE_BITS-1:0] vote,
   output logic                 any_inc
);

   always_comb begin
      vote = '0;
      for (int f = 0; f < NUM_FERNS; f++) begin
         vote = vote + VOTE_BITS'(posterior[f]);
      end
   end

   assign any_inc = |incremented;

endmodule

### design/random_fern_posterior_classifier.sv
// Top level of the random fern posterior classifier: control, thresholds and ports.
//
// Each request names one leaf per fern and a command; every request returns one
// response with the vote (the sum of the addressed Q0.16 posteriors, taken before any
// update) and a flag telling whether training changed a counter. Each fern has its
// own lane with a private leaf store, so all ferns are read and updated in parallel.
// After reset the stores are cleared by a pass over all 2^FERN_BITS leaves (8192 by
// default) during which no request is accepted; configuration writes are taken at
// any time. Every request passes through the sum and decide states; a training
// request that trains then also runs the 16-step restoring divider in each lane,
// which recomputes the posterior p/(p+n), and writes the updated leaves back.
// A finished response waits in an output register until it is taken.
module random_fern_posterior_classifier import rfpc_pkg::*; #(
   parameter int NUM_FERNS  = DEF_NUM_FERNS,
   parameter int FERN_BITS  = DEF_FERN_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_BITS-1:0]      req_cmd,
   input  logic                     req_label,
   input  logic [LEAF_BITS-1:0]     req_leaf_0,
   input  logic [LEAF_BITS-1:0]     req_leaf_1,
   input  logic [LEAF_BITS-1:0]     req_leaf_2,
   input  logic [LEAF_BITS-1:0]     req_leaf_3,
   input  logic [LEAF_BITS-1:0]     req_leaf_4,
   input  logic [LEAF_BITS-1:0]     req_leaf_5,
   input  logic [LEAF_BITS-1:0]     req_leaf_6,
   input  logic [LEAF_BITS-1:0]     req_leaf_7,
   input  logic [LEAF_BITS-1:0]     req_leaf_8,
   input  logic [LEAF_BITS-1:0]     req_leaf_9,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [VOTE_BITS-1:0]     rsp_vote_sum,
   output logic                     rsp_was_updated,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SUM    = 7'b0000100,
      S_DECIDE = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [FERN_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic [CMD_BITS-1:0]     cmd_ff;
   logic                    label_ff;
   logic [VOTE_BITS-1:0]    vote_ff;
   logic                    upd_ff, upd_in;
   logic [VOTE_BITS-1:0]    raised_ff, raised_in;
   logic [FRAC_BITS-1:0]    frac_ff;
   logic [VOTE_BITS-1:0]    neg_limit_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VOTE_BITS-1:0]    rsp_vote_ff;
   logic                    rsp_upd_ff;

   logic                    accept;
   logic                    rsp_load;
   logic                    train;
   logic [VOTE_BITS-1:0]    base_thr, pos_thr;
   lane_ctl_type            ctl;
   logic [LEAF_BITS-1:0]    leaf_arr [MAX_FERNS];
   logic [POST_BITS-1:0]    posterior [NUM_FERNS];
   logic [NUM_FERNS-1:0]    incremented;
   logic [VOTE_BITS-1:0]    vote_sum;
   logic                    any_inc;

   assign leaf_arr[0] = req_leaf_0;
   assign leaf_arr[1] = req_leaf_1;
   assign leaf_arr[2] = req_leaf_2;
   assign leaf_arr[3] = req_leaf_3;
   assign leaf_arr[4] = req_leaf_4;
   assign leaf_arr[5] = req_leaf_5;
   assign leaf_arr[6] = req_leaf_6;
   assign leaf_arr[7] = req_leaf_7;
   assign leaf_arr[8] = req_leaf_8;
   assign leaf_arr[9] = req_leaf_9;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // The positive threshold is the configured fraction scaled by the fern count,
   // raised by evaluate requests to the largest vote they have seen.
   assign base_thr = VOTE_BITS'(frac_ff * NUM_FERNS);
   assign pos_thr  = (base_thr > raised_ff) ? base_thr : raised_ff;

   // Positives train when the ensemble does not yet vote for them strongly enough;
   // negatives train when the ensemble votes for them too strongly.
   assign train = (cmd_ff == CMD_TRAIN) &&
                  (label_ff ? (vote_ff <= pos_thr) : (vote_ff >= neg_limit_ff));

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      div_cnt_in   = div_cnt_ff;
      upd_in       = upd_ff;
      raised_in    = raised_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.label    = label_ff;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ctl.rd = accept;
            if (accept) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            upd_in     = 1'b0;
            div_cnt_in = '0;
            if (cmd_ff == CMD_EVALUATE && vote_ff > pos_thr) begin
               raised_in = vote_ff;
            end
            if (train) begin
               ctl.load = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            ctl.step   = 1'b1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            ctl.write = 1'b1;
            upd_in    = any_inc;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         div_cnt_ff   <= '0;
         upd_ff       <= 1'b0;
         raised_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         frac_ff      <= FRAC_RESET;
         neg_limit_ff <= NEG_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         div_cnt_ff   <= div_cnt_in;
         upd_ff       <= upd_in;
         raised_ff    <= raised_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POS_FRACTION) begin
               frac_ff <= csr_data[FRAC_BITS-1:0];
            end else if (csr_index == CSR_NEG_LIMIT) begin
               neg_limit_ff <= csr_data[VOTE_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         label_ff <= req_label;
      end
      if (state_ff == S_SUM) begin
         vote_ff <= vote_sum;
      end
      if (rsp_load) begin
         rsp_vote_ff <= vote_ff;
         rsp_upd_ff  <= upd_ff;
      end
   end

   for (genvar f = 0; f < NUM_FERNS; f++) begin : g_lane
      logic [LEAF_EXT-1:0] leaf_ext;
      assign leaf_ext = LEAF_EXT'(leaf_arr[f]);

      rfpc_lane #(
         .FERN_BITS  (FERN_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_lane (
         .clock       (clock),
         .ctl         (ctl),
         .clear_addr  (clr_addr_ff),
         .leaf        (leaf_ext[FERN_BITS-1:0]),
         .posterior   (posterior[f]),
         .incremented (incremented[f])
      );
   end

   rfpc_merge #(
      .NUM_FERNS (NUM_FERNS)
   ) u_merge (
      .posterior   (posterior),
      .incremented (incremented),
      .vote        (vote_sum),
      .any_inc     (any_inc)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vote_sum    = rsp_vote_ff;
   assign rsp_was_updated = rsp_upd_ff;

   // The raised threshold only ever grows between resets.
   a_raised_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (raised_ff >= $past(raised_ff)))
      else $error("raised threshold decreased");

   // No request is taken while the stores are being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request accepted during clearing pass");

   // A response flagged as updated can only come from a training request.
   a_update_only_train: assert property (@(posedge clock) disable iff (reset)
      rsp_load && upd_ff |-> (cmd_ff == CMD_TRAIN))
      else $error("update flag on a non-training request");

endmodule
